/* sv/fach_pkg.sv */
// Package for the face-aware compass heading block: constants, tables, helper functions.
package fach_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned AngleItersDef  = 16;
  localparam int unsigned Guard          = 24;
  localparam int unsigned AngW           = 20;   // signed 1/256 degree angle
  localparam int unsigned MaxIters       = 24;
  localparam logic signed [AngW-1:0] Turn     = 20'sd92160;
  localparam logic signed [AngW-1:0] HalfTurn = 20'sd46080;

  typedef enum logic [1:0] {
    REG_NOSE   = 2'd0,
    REG_TARGET = 2'd1,
    REG_LEEWAY = 2'd2
  } cfg_reg_e;

  localparam logic [5:0] TurnNoses = 6'h25;

  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned i);
    logic signed [AngW-1:0] r;
    r = '0;
    case (i)
      0: r = 20'sd11520;
      1: r = 20'sd6801;
      2: r = 20'sd3593;
      3: r = 20'sd1824;
      4: r = 20'sd916;
      5: r = 20'sd458;
      6: r = 20'sd229;
      7: r = 20'sd115;
      8: r = 20'sd57;
      9: r = 20'sd29;
      10: r = 20'sd14;
      11: r = 20'sd7;
      12: r = 20'sd4;
      13: r = 20'sd2;
      14: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] mirror_lut(input logic [1:0] axis);
    logic [5:0] r;
    case (axis)
      2'd0: r = 6'h28;
      2'd1: r = 6'h11;
      2'd2: r = 6'h06;
      default: r = 6'h00;
    endcase
    return r;
  endfunction

  // clockwise side face seen from above, [up][side]
  function automatic logic [2:0] cw_lut(input logic [2:0] up, input logic [2:0] side);
    logic [2:0] r;
    r = 3'd0;
    case (up)
      3'd0: case (side) 3'd2: r = 3'd5; 3'd3: r = 3'd4; 3'd4: r = 3'd2; 3'd5: r = 3'd3;
                        default: r = 3'd0; endcase
      3'd1: case (side) 3'd2: r = 3'd4; 3'd3: r = 3'd5; 3'd4: r = 3'd3; 3'd5: r = 3'd2;
                        default: r = 3'd0; endcase
      3'd2: case (side) 3'd0: r = 3'd4; 3'd1: r = 3'd5; 3'd4: r = 3'd1;
                        default: r = 3'd0; endcase
      3'd3: case (side) 3'd0: r = 3'd5; 3'd1: r = 3'd4; 3'd5: r = 3'd1;
                        default: r = 3'd0; endcase
      3'd4: case (side) 3'd0: r = 3'd3; 3'd1: r = 3'd2; 3'd3: r = 3'd1;
                        default: r = 3'd0; endcase
      3'd5: case (side) 3'd0: r = 3'd2; 3'd1: r = 3'd3; 3'd2: r = 3'd1;
                        default: r = 3'd0; endcase
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

/* sv/face_aware_compass_heading.sv */
// Face-aware compass heading: pipelined face select, CORDIC atan2, heading post-processing.
//
// channel | direction | handshake              | payload
// in      | input     | in_valid_i / in_stall_o  | accel_x/y/z_i, mag_x/y/z_i
// out     | output    | out_valid_o / out_stall_i| up_face_o .. bearing_face_o
// cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One request accepted per cycle while in_stall_o is low; the pipeline holds
// one CORDIC iteration per stage plus face select, pre-rotation, heading and
// bearing stages. Reset clears all stage valid bits and loads register defaults.
// Out stall freezes the whole pipeline while a result is valid; in_stall_o equals
// out stall while the pipe is full at the output, so nothing is dropped or repeated.
module face_aware_compass_heading #(
  parameter int unsigned SAMPLE_WIDTH     = fach_pkg::SampleWidthDef,
  parameter int unsigned ANGLE_ITERATIONS = fach_pkg::AngleItersDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [8:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] mag_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     up_face_o,
  output logic                           heading_valid_o,
  output logic [8:0]                     heading_degrees_o,
  output logic                           pointing_correctly_o,
  output logic [2:0]                     bearing_face_o
);

  localparam int unsigned AW = fach_pkg::AngW;
  localparam int unsigned N  = ANGLE_ITERATIONS;
  // x grows by up to ~1.65*sqrt2 of |operand|*2^Guard
  localparam int unsigned CW = SAMPLE_WIDTH + fach_pkg::Guard + 3;

  // ---------------- config registers ----------------
  logic [2:0] nose_q;
  logic [8:0] target_q;
  logic [7:0] leeway_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nose_q   <= 3'd1;
      target_q <= 9'd0;
      leeway_q <= 8'd20;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fach_pkg::REG_NOSE:   nose_q   <= cfg_data_i[2:0];
        fach_pkg::REG_TARGET: target_q <= cfg_data_i;
        fach_pkg::REG_LEEWAY: leeway_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  typedef struct packed {
    logic [2:0] up;
    logic       hv;
    logic       turn;
    logic       mirror;
  } ctl_t;

  // ---------------- stage 1: up face, operand select ----------------
  logic [SAMPLE_WIDTH-1:0] abx, aby, abz;  // unsigned magnitudes
  logic [1:0]              up_axis;
  logic                    up_pos;
  logic [2:0]              up_c;
  logic [1:0]              nose_axis, oth_axis;
  logic [5:0]              turn_m, mir_m;
  ctl_t                    ctl1_d;
  logic signed [SAMPLE_WIDTH-1:0] opx, opy, asel;

  always_comb begin
    abx = accel_x_i[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-accel_x_i) : accel_x_i;
    aby = accel_y_i[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-accel_y_i) : accel_y_i;
    abz = accel_z_i[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-accel_z_i) : accel_z_i;
    if (abx > aby && abx > abz)      up_axis = 2'd0;
    else if (aby > abx && aby > abz) up_axis = 2'd1;
    else                             up_axis = 2'd2;
    case (up_axis)
      2'd0:    asel = accel_x_i;
      2'd1:    asel = accel_y_i;
      default: asel = accel_z_i;
    endcase
    up_pos    = (asel > 0);
    up_c      = {up_axis, !up_pos};
    nose_axis = nose_q[2:1];
    oth_axis  = 2'(2'd3 - nose_axis - up_axis);
    case (nose_axis)
      2'd0:    opx = mag_x_i;
      2'd1:    opx = mag_y_i;
      default: opx = mag_z_i;
    endcase
    case (oth_axis)
      2'd0:    opy = mag_x_i;
      2'd1:    opy = mag_y_i;
      default: opy = mag_z_i;
    endcase
    turn_m        = fach_pkg::TurnNoses >> nose_q;
    mir_m         = fach_pkg::mirror_lut(nose_axis) >> up_c;
    ctl1_d.up     = up_c;
    ctl1_d.hv     = (nose_q <= 3'd5) && (nose_axis != up_axis);
    ctl1_d.turn   = turn_m[0];
    ctl1_d.mirror = mir_m[0];
  end

  logic                           v1_q;
  ctl_t                           ctl1_q;
  logic [2:0]                     nose1_q;
  logic signed [SAMPLE_WIDTH-1:0] opx_q, opy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl1_q  <= ctl1_d;
      nose1_q <= nose_q;
      opx_q   <= opx;
      opy_q   <= opy;
    end
  end

  // ---------------- stage 2: scale and pre-rotate ----------------
  logic signed [CW-1:0] x0, y0;
  logic signed [AW-1:0] z0;
  logic                 zero0;
  always_comb begin
    x0    = CW'(opx_q) <<< fach_pkg::Guard;
    y0    = CW'(opy_q) <<< fach_pkg::Guard;
    zero0 = (opx_q == '0) && (opy_q == '0);
    z0    = '0;
    if (opx_q < 0) begin
      z0 = (opy_q >= 0) ? fach_pkg::HalfTurn : -fach_pkg::HalfTurn;
      x0 = -x0;
      y0 = -y0;
    end
  end

  logic                 cv_q   [N+1];
  ctl_t                 cc_q   [N+1];
  logic [2:0]           cn_q   [N+1];
  logic                 cz_q   [N+1];
  logic signed [CW-1:0] cx_q   [N+1];
  logic signed [CW-1:0] cy_q   [N+1];
  logic signed [AW-1:0] czz_q  [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q[0] <= 1'b0;
    else if (adv) cv_q[0] <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cc_q[0]  <= ctl1_q;
      cn_q[0]  <= nose1_q;
      cz_q[0]  <= zero0;
      cx_q[0]  <= x0;
      cy_q[0]  <= y0;
      czz_q[0] <= z0;
    end
  end

  // ---------------- CORDIC stages, one iteration each ----------------
  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [CW-1:0] xs, ys, xn, yn;
    logic signed [AW-1:0] zn;
    always_comb begin
      xs = cx_q[i] >>> i;
      ys = cy_q[i] >>> i;
      if (cy_q[i] > 0) begin
        xn = cx_q[i] + ys;
        yn = cy_q[i] - xs;
        zn = czz_q[i] + fach_pkg::atan_lut(i);
      end else begin
        xn = cx_q[i] - ys;
        yn = cy_q[i] + xs;
        zn = czz_q[i] - fach_pkg::atan_lut(i);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[i+1] <= 1'b0;
      else if (adv) cv_q[i+1] <= cv_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cc_q[i+1]  <= cc_q[i];
        cn_q[i+1]  <= cn_q[i];
        cz_q[i+1]  <= cz_q[i];
        cx_q[i+1]  <= xn;
        cy_q[i+1]  <= yn;
        czz_q[i+1] <= zn;
      end
    end
  end

  // ---------------- heading stage: turn, mirror, round ----------------
  logic signed [AW:0] h0, h1, h2;
  logic [9:0]         deg_c;
  logic [8:0]         deg_d;
  always_comb begin
    h0 = cz_q[N] ? '0 : (AW+1)'(czz_q[N]);
    if (cc_q[N].turn) h0 = h0 + (AW+1)'(fach_pkg::HalfTurn);
    h1 = h0;
    if (h1 < 0) h1 = h1 + (AW+1)'(fach_pkg::Turn);
    else if (h1 >= (AW+1)'(fach_pkg::Turn)) h1 = h1 - (AW+1)'(fach_pkg::Turn);
    h2 = h1;
    if (cc_q[N].mirror) h2 = (AW+1)'(fach_pkg::Turn) - h1;
    if (h2 >= (AW+1)'(fach_pkg::Turn)) h2 = h2 - (AW+1)'(fach_pkg::Turn);
    deg_c = 10'((h2 + 21'sd128) >>> 8);
    deg_d = (deg_c >= 10'd360) ? 9'(deg_c - 10'd360) : deg_c[8:0];
  end

  logic       vh_q;
  ctl_t       ch_q;
  logic [2:0] nh_q;
  logic [8:0] degh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (adv) vh_q <= cv_q[N];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ch_q   <= cc_q[N];
      nh_q   <= cn_q[N];
      degh_q <= deg_d;
    end
  end

  // ---------------- output stage: error, nearest face ----------------
  logic [8:0] tgt, err, off;
  logic [9:0] offs;
  logic [2:0] face;
  logic       point;
  always_comb begin
    tgt  = (target_q >= 9'd360) ? 9'(target_q - 9'd360) : target_q;
    err  = (degh_q > tgt) ? 9'(degh_q - tgt) : 9'(tgt - degh_q);
    if (err > 9'd180) err = 9'(9'd360 - err);
    offs = 10'(degh_q) + 10'd360 - 10'(tgt);
    off  = (offs >= 10'd360) ? 9'(offs - 10'd360) : offs[8:0];
    if (off >= 9'd315 || off < 9'd45) face = nh_q;
    else if (off < 9'd135)            face = fach_pkg::cw_lut(ch_q.up, nh_q ^ 3'd1);
    else if (off < 9'd225)            face = nh_q ^ 3'd1;
    else                              face = fach_pkg::cw_lut(ch_q.up, nh_q);
    point = (err <= {1'b0, leeway_q});
  end

  logic       vo_q;
  logic [2:0] upo_q, faceo_q;
  logic       hvo_q, pto_q;
  logic [8:0] dego_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vo_q <= 1'b0;
    else if (adv) vo_q <= vh_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      upo_q   <= ch_q.up;
      hvo_q   <= ch_q.hv;
      dego_q  <= ch_q.hv ? degh_q : 9'd0;
      pto_q   <= ch_q.hv && point;
      faceo_q <= ch_q.hv ? face : 3'd0;
    end
  end

  assign out_valid_o          = vo_q;
  assign up_face_o            = upo_q;
  assign heading_valid_o      = hvo_q;
  assign heading_degrees_o    = dego_q;
  assign pointing_correctly_o = pto_q;
  assign bearing_face_o       = faceo_q;

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(heading_degrees_o))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !heading_valid_o) |->
      (heading_degrees_o == 9'd0 && !pointing_correctly_o && bearing_face_o == 3'd0))
    else $error("invalid heading with nonzero fields");
  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_degrees_o < 9'd360 && up_face_o < 3'd6))
    else $error("heading or face out of range");

endmodule
